@@ src/mbr_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the Modbus RTU read master.
// No dependencies; the design modules and the testbench refer to it by scoped names.
package mbr_pkg;

  localparam int ATTEMPTS_DEFAULT = 2;
  localparam int QUEUE_DEPTH = 2;  // power of two

  localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd237;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_FRAME = 2'd1;
  localparam logic [1:0] STAT_BAD_CRC   = 2'd2;

  localparam logic [2:0] REQ_LAST_STEP = 3'd7;
  localparam logic [2:0] REQ_CRC_STEP  = 3'd6;

  typedef enum logic {
    PH_IDLE,
    PH_WAIT
  } phase_t;

  typedef enum logic [1:0] {
    JOB_REQ,
    JOB_DATA,
    JOB_DATA_STAT,
    JOB_STAT
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [6:0]  count;
    logic [7:0]  byte_val;
    logic [1:0]  status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/mbr_item_if.sv @@
// Input channel of the read master: command, request fields and one response byte.
// Uses valid/ready; no package dependency.
interface mbr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] reg_addr;
  logic [6:0]  reg_count;
  logic [7:0]  rx_byte;
  logic        frame_end;

  modport source (output valid, cmd, reg_addr, reg_count, rx_byte, frame_end, input ready);
  modport sink (input valid, cmd, reg_addr, reg_count, rx_byte, frame_end, output ready);
endinterface

@@ src/mbr_result_if.sv @@
// Result channel of the read master: request bytes, data bytes and status.
// Uses valid/ready; no package dependency.
interface mbr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_val;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, byte_val, status, last, input ready);
  modport sink (input valid, kind, byte_val, status, last, output ready);
endinterface

@@ src/mbr_cfg_if.sv @@
// Configuration write channel: slave address write data with valid/ready.
// No package dependency.
interface mbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/modbus_rtu_read_master.sv @@
// Modbus RTU read-holding-registers master. An item is accepted in the cycle it arrives
// while the two-entry job queue has room. A request (or retry) emits 8 result items, one
// per cycle while result.ready is high, from the back end byte sequencer; a response byte
// gives 0, 1 or 2 items at one per cycle while result.ready is high.
// Synchronous reset clears transaction state, empties the queue, slave address 237.
module modbus_rtu_read_master #(
  parameter int ATTEMPTS = mbr_pkg::ATTEMPTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  mbr_cfg_if.sink      cfg,
  mbr_item_if.sink     item,
  mbr_result_if.source result
);

  logic               push;
  logic               pop;
  mbr_pkg::job_t      job;
  mbr_pkg::job_t      head;
  mbr_pkg::q_status_t qs;

  mbr_front #(
    .ATTEMPTS(ATTEMPTS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cfg  (cfg),
    .qs   (qs),
    .push (push),
    .job  (job)
  );

  mbr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job),
    .pop  (pop),
    .head (head),
    .qs   (qs)
  );

  mbr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qs     (qs),
    .pop    (pop),
    .result (result)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qs.full || pop)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qs.empty)
    else $error("job queue underflow");

  a_req_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && (result.kind == mbr_pkg::KIND_REQ) && !result.last)
    |=> (result.valid && (result.kind == mbr_pkg::KIND_REQ)))
    else $error("request bytes interrupted");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.kind == mbr_pkg::KIND_STAT)) |-> result.last)
    else $error("status item without last");
`endif

endmodule

@@ src/mbr_front.sv @@
// Front end: accepts items, tracks the transaction and response checks, queues jobs.
// Depends on mbr_pkg, mbr_item_if and mbr_cfg_if.
module mbr_front #(
  parameter int ATTEMPTS = mbr_pkg::ATTEMPTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  mbr_item_if.sink          item,
  mbr_cfg_if.sink           cfg,
  input  mbr_pkg::q_status_t qs,
  output logic              push,
  output mbr_pkg::job_t     job
);

  localparam int RW = (ATTEMPTS > 1) ? $clog2(ATTEMPTS) : 1;

  logic [7:0]      slave_address;
  logic [15:0]     req_address, req_address_next;
  logic [6:0]      req_count, req_count_next;
  logic [15:0]     running_crc, running_crc_next;
  logic [7:0]      rx_index, rx_index_next;
  logic            header_bad, header_bad_next;
  logic [RW-1:0]   retry_used, retry_used_next;
  mbr_pkg::phase_t phase, phase_next;

  logic        accept;
  logic [7:0]  twice;
  logic [8:0]  total;
  logic [8:0]  data_end;
  logic [7:0]  idx_inc;
  logic [15:0] crc_b;
  logic        hb_b;
  logic        is_data;
  logic        retry_can;

  function automatic logic short_bad(input logic [7:0] idx, input logic hb,
                                     input logic [7:0] tw);
    return hb || (idx < 8'd2) || ((idx == 8'd2) && (tw != 8'd0));
  endfunction

  assign item.ready = !qs.full;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;

  assign twice     = {req_count, 1'b0};
  assign total     = {1'b0, twice} + 9'd5;
  assign data_end  = {1'b0, twice} + 9'd3;
  assign idx_inc   = rx_index + 8'd1;
  assign crc_b     = mbr_pkg::crc16_byte(running_crc, item.rx_byte);
  assign hb_b      = header_bad
                   || ((rx_index == 8'd1) && (item.rx_byte != mbr_pkg::FUNC_READ_HOLDING))
                   || ((rx_index == 8'd2) && (item.rx_byte != twice));
  assign is_data   = (rx_index >= 8'd3) && ({1'b0, rx_index} < data_end) && !hb_b;
  assign retry_can = {1'b0, retry_used} < (RW + 1)'(ATTEMPTS - 1);

  always_comb begin
    req_address_next = req_address;
    req_count_next   = req_count;
    running_crc_next = running_crc;
    rx_index_next    = rx_index;
    header_bad_next  = header_bad;
    retry_used_next  = retry_used;
    phase_next       = phase;
    push             = 1'b0;
    job              = '0;
    job.op           = mbr_pkg::JOB_STAT;
    job.slave        = slave_address;
    job.addr         = req_address;
    job.count        = req_count;
    if (accept) begin
      case (item.cmd)
        mbr_pkg::CMD_REQUEST: begin
          req_address_next = item.reg_addr;
          req_count_next   = item.reg_count;
          retry_used_next  = '0;
          running_crc_next = mbr_pkg::CRC_INIT;
          rx_index_next    = '0;
          header_bad_next  = 1'b0;
          phase_next       = mbr_pkg::PH_WAIT;
          push             = 1'b1;
          job.op           = mbr_pkg::JOB_REQ;
          job.addr         = item.reg_addr;
          job.count        = item.reg_count;
        end
        mbr_pkg::CMD_TIMEOUT: begin
          if (phase == mbr_pkg::PH_WAIT) begin
            if (rx_index != 8'd0) begin
              push       = 1'b1;
              job.status = short_bad(rx_index, header_bad, twice) ?
                           mbr_pkg::STAT_BAD_FRAME : mbr_pkg::STAT_BAD_CRC;
              phase_next = mbr_pkg::PH_IDLE;
            end else if (retry_can) begin
              retry_used_next  = retry_used + 1'b1;
              running_crc_next = mbr_pkg::CRC_INIT;
              header_bad_next  = 1'b0;
              push             = 1'b1;
              job.op           = mbr_pkg::JOB_REQ;
            end else begin
              push       = 1'b1;
              job.status = mbr_pkg::STAT_BAD_FRAME;
              phase_next = mbr_pkg::PH_IDLE;
            end
          end
        end
        mbr_pkg::CMD_BYTE: begin
          if (phase == mbr_pkg::PH_WAIT) begin
            if (rx_index == 8'hFF) begin
              if (item.frame_end) begin
                push       = 1'b1;
                job.status = short_bad(rx_index, header_bad, twice) ?
                             mbr_pkg::STAT_BAD_FRAME : mbr_pkg::STAT_BAD_CRC;
                phase_next = mbr_pkg::PH_IDLE;
              end
            end else begin
              running_crc_next = crc_b;
              header_bad_next  = hb_b;
              rx_index_next    = idx_inc;
              job.byte_val     = item.rx_byte;
              if ({1'b0, idx_inc} == total) begin
                push       = 1'b1;
                job.status = hb_b ? mbr_pkg::STAT_BAD_FRAME :
                             ((crc_b != 16'd0) ? mbr_pkg::STAT_BAD_CRC : mbr_pkg::STAT_OK);
                phase_next = mbr_pkg::PH_IDLE;
              end else if (item.frame_end) begin
                push       = 1'b1;
                job.op     = is_data ? mbr_pkg::JOB_DATA_STAT : mbr_pkg::JOB_STAT;
                job.status = short_bad(idx_inc, hb_b, twice) ?
                             mbr_pkg::STAT_BAD_FRAME : mbr_pkg::STAT_BAD_CRC;
                phase_next = mbr_pkg::PH_IDLE;
              end else if (is_data) begin
                push   = 1'b1;
                job.op = mbr_pkg::JOB_DATA;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mbr_pkg::PH_IDLE;
      slave_address <= mbr_pkg::SLAVE_ADDR_RESET;
      req_address   <= '0;
      req_count     <= '0;
      running_crc   <= mbr_pkg::CRC_INIT;
      rx_index      <= '0;
      header_bad    <= 1'b0;
      retry_used    <= '0;
    end else begin
      phase       <= phase_next;
      req_address <= req_address_next;
      req_count   <= req_count_next;
      running_crc <= running_crc_next;
      rx_index    <= rx_index_next;
      header_bad  <= header_bad_next;
      retry_used  <= retry_used_next;
      if (cfg.valid) begin
        slave_address <= cfg.data;
      end
    end
  end

endmodule

@@ src/mbr_queue.sv @@
// Short job queue between the front and back ends.
// Depends on mbr_pkg for the job type and depth.
module mbr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mbr_pkg::job_t      din,
  input  logic               pop,
  output mbr_pkg::job_t      head,
  output mbr_pkg::q_status_t qs
);

  localparam int PW = (mbr_pkg::QUEUE_DEPTH > 1) ? $clog2(mbr_pkg::QUEUE_DEPTH) : 1;

  mbr_pkg::job_t entries [mbr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign head     = entries[rd_ptr];
  assign qs.full  = (count == (PW + 1)'(mbr_pkg::QUEUE_DEPTH));
  assign qs.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/mbr_back.sv @@
// Back end: expands queued jobs into result items, building request bytes and CRC.
// Depends on mbr_pkg and mbr_result_if.
module mbr_back (
  input  logic               clk,
  input  logic               rst,
  input  mbr_pkg::job_t      head,
  input  mbr_pkg::q_status_t qs,
  output logic               pop,
  mbr_result_if.source       result
);

  logic          busy;
  mbr_pkg::job_t cur;
  logic [2:0]    step;
  logic [15:0]   crc;
  logic          fire;
  logic          final_step;
  logic [7:0]    req_byte;

  assign fire = result.valid && result.ready;
  assign pop  = !qs.empty && (!busy || (fire && final_step));

  always_comb begin
    case (step)
      3'd0:    req_byte = cur.slave;
      3'd1:    req_byte = mbr_pkg::FUNC_READ_HOLDING;
      3'd2:    req_byte = cur.addr[15:8];
      3'd3:    req_byte = cur.addr[7:0];
      3'd4:    req_byte = 8'h00;
      3'd5:    req_byte = {1'b0, cur.count};
      3'd6:    req_byte = crc[7:0];
      default: req_byte = crc[15:8];
    endcase
  end

  always_comb begin
    result.valid    = busy;
    result.kind     = mbr_pkg::KIND_STAT;
    result.byte_val = 8'h00;
    result.status   = mbr_pkg::STAT_OK;
    result.last     = 1'b1;
    final_step      = 1'b1;
    case (cur.op)
      mbr_pkg::JOB_REQ: begin
        result.kind     = mbr_pkg::KIND_REQ;
        result.byte_val = req_byte;
        result.last     = (step == mbr_pkg::REQ_LAST_STEP);
        final_step      = (step == mbr_pkg::REQ_LAST_STEP);
      end
      mbr_pkg::JOB_DATA: begin
        result.kind     = mbr_pkg::KIND_DATA;
        result.byte_val = cur.byte_val;
      end
      mbr_pkg::JOB_DATA_STAT: begin
        final_step = (step == 3'd1);
        if (step == 3'd0) begin
          result.kind     = mbr_pkg::KIND_DATA;
          result.byte_val = cur.byte_val;
          result.last     = 1'b0;
        end else begin
          result.status = cur.status;
        end
      end
      default: begin
        result.status = cur.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      crc <= mbr_pkg::CRC_INIT;
    end else if (fire && !final_step && (cur.op == mbr_pkg::JOB_REQ)
                 && (step < mbr_pkg::REQ_CRC_STEP)) begin
      crc <= mbr_pkg::crc16_byte(crc, req_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      step <= '0;
    end else if (fire && final_step) begin
      busy <= 1'b0;
    end else if (fire) begin
      step <= step + 3'd1;
    end
  end

endmodule

@@ dv/tb_modbus_rtu_read_master.sv @@
// Testbench for modbus_rtu_read_master: directed and random read transactions with
// random flow control on both channels, checked item by item against a behavioral predictor.
// Depends on src/mbr_pkg.sv, the three channel interfaces and the RTL top level.
module tb_modbus_rtu_read_master;

  localparam int ATTEMPTS = mbr_pkg::ATTEMPTS_DEFAULT;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASE_ITEMS = 30;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_val;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } stall_t;

  logic clk;
  logic rst;

  mbr_item_if   in_if();
  mbr_result_if out_if();
  mbr_cfg_if    cfg_if();

  modbus_rtu_read_master #(.ATTEMPTS(ATTEMPTS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .item(in_if),
    .result(out_if)
  );

  result_t    expected_results[$];
  logic [7:0] frame_bytes[$];
  int         error_count = 0;
  int         useful_items = 0;
  int         burst_left = 0;
  bit         hold_off_req = 1'b0;

  // predictor state
  logic [7:0]  pred_slave = mbr_pkg::SLAVE_ADDR_RESET;
  logic [15:0] pred_addr = '0;
  logic [6:0]  pred_count = '0;
  logic [15:0] pred_crc = mbr_pkg::CRC_INIT;
  logic [7:0]  pred_index = '0;
  bit          pred_hdr_bad = 1'b0;
  int          pred_retries = 0;
  bit          pred_waiting = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic lsb;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      lsb = c[0];
      c = c >> 1;
      if (lsb) c = c ^ mbr_pkg::CRC_POLY;
    end
    return c;
  endfunction

  task automatic push_result(logic [1:0] kind, logic [7:0] val, logic [1:0] st, logic lst);
    result_t r;
    r.kind = kind;
    r.byte_val = val;
    r.status = st;
    r.last = lst;
    expected_results.push_back(r);
  endtask

  task automatic emit_request_bytes();
    logic [7:0] req[8];
    logic [15:0] c;
    req[0] = pred_slave;
    req[1] = mbr_pkg::FUNC_READ_HOLDING;
    req[2] = pred_addr[15:8];
    req[3] = pred_addr[7:0];
    req[4] = 8'h00;
    req[5] = {1'b0, pred_count};
    c = mbr_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc_update(c, req[i]);
    req[6] = c[7:0];
    req[7] = c[15:8];
    for (int i = 0; i < 8; i++)
      push_result(mbr_pkg::KIND_REQ, req[i], mbr_pkg::STAT_OK, i == 7);
    pred_crc = mbr_pkg::CRC_INIT;
    pred_index = '0;
    pred_hdr_bad = 1'b0;
    pred_waiting = 1'b1;
  endtask

  task automatic close_short_frame();
    bit bad;
    bad = pred_hdr_bad;
    if (pred_index < 2) bad = 1'b1;
    else if (pred_index == 2 && {pred_count, 1'b0} != 8'h00) bad = 1'b1;
    push_result(mbr_pkg::KIND_STAT, 8'h00,
                bad ? mbr_pkg::STAT_BAD_FRAME : mbr_pkg::STAT_BAD_CRC, 1'b1);
    pred_waiting = 1'b0;
  endtask

  task automatic predict_master(logic [1:0] cmd, logic [15:0] addr, logic [6:0] cnt,
                                logic [7:0] b, logic fe);
    int total;
    int idx;
    if (cmd == mbr_pkg::CMD_REQUEST) begin
      useful_items++;
      pred_addr = addr;
      pred_count = cnt;
      pred_retries = 0;
      emit_request_bytes();
      return;
    end
    if (!pred_waiting) return;
    if (cmd == mbr_pkg::CMD_TIMEOUT) begin
      useful_items++;
      if (pred_index != 0) close_short_frame();
      else if (pred_retries + 1 < ATTEMPTS) begin
        pred_retries++;
        emit_request_bytes();
      end else begin
        push_result(mbr_pkg::KIND_STAT, 8'h00, mbr_pkg::STAT_BAD_FRAME, 1'b1);
        pred_waiting = 1'b0;
      end
      return;
    end
    if (cmd != mbr_pkg::CMD_BYTE) return;
    if (pred_index == 8'd255) begin
      if (fe) begin
        useful_items++;
        close_short_frame();
      end
      return;
    end
    useful_items++;
    total = 2 * pred_count + 5;
    idx = pred_index;
    pred_crc = crc_update(pred_crc, b);
    if (idx == 1 && b != mbr_pkg::FUNC_READ_HOLDING) pred_hdr_bad = 1'b1;
    if (idx == 2 && b != {pred_count, 1'b0}) pred_hdr_bad = 1'b1;
    pred_index = 8'(idx + 1);
    if (idx + 1 == total) begin
      push_result(mbr_pkg::KIND_STAT, 8'h00,
                  pred_hdr_bad ? mbr_pkg::STAT_BAD_FRAME :
                  (pred_crc != 0 ? mbr_pkg::STAT_BAD_CRC : mbr_pkg::STAT_OK), 1'b1);
      pred_waiting = 1'b0;
      return;
    end
    if (idx >= 3 && idx < 3 + 2 * pred_count && !pred_hdr_bad)
      push_result(mbr_pkg::KIND_DATA, b, mbr_pkg::STAT_OK, !fe);
    if (fe) close_short_frame();
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result with none pending: kind %0d byte 0x%0h status %0d",
                               out_if.kind, out_if.byte_val, out_if.status));
      end else begin
        want = expected_results.pop_front();
        if (out_if.kind !== want.kind)
          report_error($sformatf("kind got %0d expected %0d", out_if.kind, want.kind));
        if (out_if.byte_val !== want.byte_val)
          report_error($sformatf("byte_val got 0x%0h expected 0x%0h",
                                 out_if.byte_val, want.byte_val));
        if (out_if.status !== want.status)
          report_error($sformatf("status got %0d expected %0d", out_if.status, want.status));
        if (out_if.last !== want.last)
          report_error($sformatf("last got %0b expected %0b", out_if.last, want.last));
      end
    end
  end

  // result receiver flow control
  initial begin : result_stalls
    stall_t mode;
    int mode_left;
    int rx_cycle;
    mode = RX_ALWAYS;
    mode_left = 0;
    rx_cycle = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = stall_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_COIN: out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] addr, logic [6:0] cnt,
                           logic [7:0] b, logic fe);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.reg_addr <= addr;
    in_if.reg_count <= cnt;
    in_if.rx_byte <= b;
    in_if.frame_end <= fe;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    predict_master(cmd, addr, cnt, b, fe);
  endtask

  task automatic send_request(logic [15:0] addr, logic [6:0] cnt);
    send_item(mbr_pkg::CMD_REQUEST, addr, cnt, 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_byte(logic [7:0] b, logic fe);
    send_item(mbr_pkg::CMD_BYTE, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
              b, fe);
  endtask

  task automatic send_other(logic [1:0] cmd);
    send_item(cmd, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_slave_address(logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    pred_slave = value;
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic fill_frame(int cnt);
    logic [7:0] v;
    frame_bytes = {};
    frame_bytes.push_back(pred_slave);
    frame_bytes.push_back(mbr_pkg::FUNC_READ_HOLDING);
    v = 8'(2 * cnt);
    frame_bytes.push_back(v);
    for (int i = 0; i < 2 * cnt; i++) begin
      v = 8'($urandom_range(0, 255));
      frame_bytes.push_back(v);
    end
  endtask

  task automatic seal_frame();
    logic [15:0] c;
    c = mbr_pkg::CRC_INIT;
    foreach (frame_bytes[i]) c = crc_update(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic send_frame(int n, bit close);
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], close && i == n - 1);
  endtask

  task automatic test_reset_slave_address();
    send_request(16'h0000, 7'd0);
    fill_frame(0);
    seal_frame();
    send_frame(frame_bytes.size(), 1'b1);
    wait_for_drain();
  endtask

  task automatic test_slave_address_extremes();
    write_slave_address(8'h00);
    send_request(16'hFFFF, 7'd1);
    frame_bytes = {pred_slave, mbr_pkg::FUNC_READ_HOLDING, 8'h02, 8'hFF, 8'h00};
    seal_frame();
    send_frame(frame_bytes.size(), 1'b1);
    wait_for_drain();
    write_slave_address(8'hFF);
  endtask

  task automatic test_timeouts_and_ignored();
    send_other(mbr_pkg::CMD_TIMEOUT);
    send_byte(8'h5A, 1'b1);
    send_other(CMD_UNUSED);
    send_request(16'h8001, 7'd127);
    send_other(CMD_UNUSED);
    send_other(mbr_pkg::CMD_TIMEOUT);
    send_other(mbr_pkg::CMD_TIMEOUT);
    wait_for_drain();
  endtask

  task automatic test_short_frames();
    send_request(16'h00FF, 7'd2);
    send_byte(pred_slave, 1'b1);
    send_request(16'h7F00, 7'd0);
    send_byte(pred_slave, 1'b0);
    send_byte(mbr_pkg::FUNC_READ_HOLDING, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_for_drain();
  endtask

  task automatic run_random_transaction();
    int cnt;
    int pick;
    int n;
    logic [7:0] flip;
    pick = $urandom_range(0, 99);
    cnt = pick < 85 ? $urandom_range(0, 5) : (pick < 98 ? $urandom_range(6, 16)
                                                        : $urandom_range(17, 40));
    send_request(16'($urandom_range(0, 65535)), 7'(cnt));
    fill_frame(cnt);
    flip = 8'($urandom_range(1, 255));
    pick = $urandom_range(0, 99);
    if (pick >= 70 && pick < 80) frame_bytes[1] = frame_bytes[1] ^ flip;
    else if (pick >= 80 && pick < 88) frame_bytes[2] = frame_bytes[2] ^ flip;
    seal_frame();
    if (pick >= 88) begin
      n = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[n] = frame_bytes[n] ^ (8'h01 << $urandom_range(0, 7));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      send_frame(frame_bytes.size(), 1'b1);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else if (pick < 72) begin
      send_frame($urandom_range(1, frame_bytes.size() - 1), 1'b1);
    end else if (pick < 80) begin
      send_frame($urandom_range(0, frame_bytes.size() - 1), 1'b0);
      send_other(mbr_pkg::CMD_TIMEOUT);
    end else if (pick < 92) begin
      send_other(mbr_pkg::CMD_TIMEOUT);
      if ($urandom_range(0, 1)) send_other(mbr_pkg::CMD_TIMEOUT);
      else send_frame(frame_bytes.size(), 1'b1);
    end else begin
      // abandoned mid-frame; the next request restarts the transaction
      send_frame($urandom_range(0, frame_bytes.size() - 1), 1'b0);
    end
    if ($urandom_range(0, 7) == 0) begin
      pick = $urandom_range(0, 2);
      send_other(pick == 0 ? mbr_pkg::CMD_BYTE :
                 (pick == 1 ? mbr_pkg::CMD_TIMEOUT : CMD_UNUSED));
    end
  endtask

  task automatic test_random_transactions();
    int goal;
    for (int p = 0; p < 4; p++) begin
      write_slave_address(8'($urandom_range(0, 255)));
      goal = useful_items + RANDOM_PHASE_ITEMS;
      while (useful_items < goal) run_random_transaction();
      wait_for_drain();
    end
  endtask

  task automatic test_input_backpressure();
    hold_off_req = 1'b1;
    burst_left = 1000;
    repeat (6) send_request(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
    wait_for_drain();
  endtask

  task automatic test_index_cap();
    write_slave_address(8'($urandom_range(0, 255)));
    send_request(16'($urandom_range(0, 65535)), 7'd127);
    fill_frame(127);
    seal_frame();
    send_frame(frame_bytes.size(), 1'b1);
    wait_for_drain();
  endtask

  initial begin
    rst <= 1'b1;
    in_if.valid <= 1'b0;
    in_if.cmd <= mbr_pkg::CMD_REQUEST;
    in_if.reg_addr <= '0;
    in_if.reg_count <= '0;
    in_if.rx_byte <= '0;
    in_if.frame_end <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_slave_address();
    test_slave_address_extremes();
    test_timeouts_and_ignored();
    test_short_frames();
    test_random_transactions();
    test_input_backpressure();
    test_index_cap();
    wait_for_drain();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
